FILE: rtl/core/bba_pkg.sv
package bba_pkg;

    // width of a block index on the ports and in the config register
    localparam int IDX_W = 10;

    // request kinds carried on s_tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

FILE: rtl/core/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bba_scan_unit.sv
module bba_scan_unit
    import bba_pkg::*;
#(
    parameter int BLOCK_COUNT = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic [IDX_W-1:0]                                         target,
    input  logic [$clog2(BLOCK_COUNT + WORD_BITS + 1)-1:0]           base,
    input  logic [WORD_BITS-1:0]                                     word,
    input  logic                                                     last_word,
    output logic                                                     in_word,
    output logic [$clog2(WORD_BITS)-1:0]                             bit_sel,
    output logic                                                     has_free,
    output logic [$clog2(WORD_BITS)-1:0]                             free_pos
);

    localparam int BASE_W     = $clog2(BLOCK_COUNT + WORD_BITS + 1);
    localparam int PW         = $clog2(WORD_BITS);
    localparam int VAL_W      = (BASE_W > IDX_W) ? BASE_W : IDX_W;
    localparam int REM_W      = VAL_W + 1;
    localparam int WORD_COUNT = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_BITS  = BLOCK_COUNT - (WORD_COUNT - 1) * WORD_BITS;

    logic [REM_W-1:0]     rem;
    logic                 rem_neg;
    logic                 past_word;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] end_mask;
    logic [WORD_BITS-1:0] masked;

    // distance of the target block from the first block of this word
    assign rem       = REM_W'(target) - REM_W'(base);
    assign rem_neg   = rem[REM_W-1];
    assign in_word   = !rem_neg && (rem < REM_W'(WORD_BITS));
    assign past_word = !rem_neg && !in_word;
    assign bit_sel   = rem[PW-1:0];

    // blocks below the target and beyond the disk count as used
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            low_mask[i] = past_word || (in_word && (PW'(i) < bit_sel));
            end_mask[i] = last_word && (i >= LAST_BITS);
        end
    end

    assign masked   = word | low_mask | end_mask;
    assign has_free = ~&masked;

    // lowest clear bit of the masked word
    always_comb begin
        free_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                free_pos = PW'(i);
            end
        end
    end

endmodule

FILE: rtl/core/bitmap_block_allocator.sv
// First-fit block allocator over a used/free bitmap, one bit per block.
// Input channel s_*: s_tuser selects allocate (0) or free (1), s_tdata holds
// the block to free. An allocate yields one result transaction on m_*:
// m_tdata the allocated block, m_tuser high when a free block was found.
// A free yields no result; a free index at or beyond BLOCK_COUNT is dropped.
// first_data_block is written through cfg_wr_en / cfg_wr_data; the user is
// to write it only while idle, which the block itself does not enforce.
// The bitmap sits in a RAM of WORD_BITS-wide words, checked one word per
// cycle by a shared scan unit (mask, range compare, find-first-clear).
// Allocate: a read, then a scan of up to BLOCK_COUNT/WORD_BITS words (32 by
// default), a write of the found bit on a hit, and the output step.
// Free: steps one word at a time up to and including the block's word, then
// does the read-modify-write. One transaction is worked on at a time.
// After reset the RAM is cleared one word per cycle with s_tready low, all
// BLOCK_COUNT/WORD_BITS words, 32 by default; config writes are still taken.
// A result waits in the output register while m_tready is low; a following
// request is accepted meanwhile and stalls only when its own result is due.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int BLOCK_COUNT = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,   // first_data_block
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [9:0] block to free, rest zero
    input  logic [0:0]  s_tuser,       // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [9:0] allocated_block, rest zero
    output logic [0:0]  m_tuser        // [0] found
);

    localparam int WORD_COUNT = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BASE_W     = $clog2(BLOCK_COUNT + WORD_BITS + 1);
    localparam int PW         = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE_SEEK,
        ST_FREE_MOD,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_ALLOC_WR,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        word_addr_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [IDX_W-1:0]     fdb_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [PW-1:0]        pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [IDX_W-1:0]     res_block_reg;
    logic                 res_found_reg;
    logic                 m_tvalid_reg;
    logic [IDX_W-1:0]     m_block_reg;
    logic                 m_found_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [IDX_W-1:0]     scan_target;
    logic                 scan_last;
    logic                 scan_in_word;
    logic [PW-1:0]        scan_bit_sel;
    logic                 scan_has_free;
    logic [PW-1:0]        scan_free_pos;
    logic                 at_last_word;
    logic [WORD_BITS-1:0] one_bit;

    // bitmap storage
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared per-word scan unit
    assign at_last_word = (word_addr_reg == AW'(WORD_COUNT - 1));
    assign scan_target  = (state_reg == ST_FREE_SEEK) ? idx_reg : fdb_reg;
    assign scan_last    = at_last_word;

    bba_scan_unit #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_scan (
        .target    (scan_target),
        .base      (base_reg),
        .word      (ram_rdata),
        .last_word (scan_last),
        .in_word   (scan_in_word),
        .bit_sel   (scan_bit_sel),
        .has_free  (scan_has_free),
        .free_pos  (scan_free_pos)
    );

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = word_addr_reg;
        ram_wdata = '0;
        ram_raddr = word_addr_reg;
        one_bit   = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_FREE_MOD: begin
                one_bit   = WORD_BITS'(1) << pos_reg;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~one_bit;
            end
            ST_ALLOC_CHK: begin
                ram_raddr = AW'(word_addr_reg + 1'b1);
            end
            ST_ALLOC_WR: begin
                one_bit   = WORD_BITS'(1) << pos_reg;
                ram_we    = 1'b1;
                ram_wdata = word_reg | one_bit;
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer, config register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            word_addr_reg <= '0;
            fdb_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                fdb_reg <= cfg_wr_data;
            end
            // the output state reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (at_last_word) begin
                        state_reg <= ST_IDLE;
                    end
                    word_addr_reg <= AW'(word_addr_reg + 1'b1);
                end
                ST_IDLE: begin
                    word_addr_reg <= '0;
                    base_reg      <= '0;
                    idx_reg       <= s_tdata[IDX_W-1:0];
                    if (s_tvalid) begin
                        if (s_tuser[0] == MODE_ALLOC) begin
                            state_reg <= ST_ALLOC_RD;
                        end else if (32'(s_tdata[IDX_W-1:0]) < BLOCK_COUNT) begin
                            state_reg <= ST_FREE_SEEK;
                        end
                    end
                end
                ST_FREE_SEEK: begin
                    // step words until the one that holds the block
                    if (scan_in_word) begin
                        pos_reg   <= scan_bit_sel;
                        state_reg <= ST_FREE_MOD;
                    end else begin
                        word_addr_reg <= AW'(word_addr_reg + 1'b1);
                        base_reg      <= BASE_W'(base_reg + BASE_W'(WORD_BITS));
                    end
                end
                ST_FREE_MOD: begin
                    state_reg <= ST_IDLE;
                end
                ST_ALLOC_RD: begin
                    state_reg <= ST_ALLOC_CHK;
                end
                ST_ALLOC_CHK: begin
                    // one word checked per cycle, next read already issued
                    if (scan_has_free) begin
                        pos_reg       <= scan_free_pos;
                        word_reg      <= ram_rdata;
                        res_block_reg <= IDX_W'(base_reg + BASE_W'(scan_free_pos));
                        res_found_reg <= 1'b1;
                        state_reg     <= ST_ALLOC_WR;
                    end else if (at_last_word) begin
                        res_block_reg <= '0;
                        res_found_reg <= 1'b0;
                        state_reg     <= ST_OUT;
                    end else begin
                        word_addr_reg <= AW'(word_addr_reg + 1'b1);
                        base_reg      <= BASE_W'(base_reg + BASE_W'(WORD_BITS));
                    end
                end
                ST_ALLOC_WR: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hand the result over once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_block_reg  <= res_block_reg;
                        m_found_reg  <= res_found_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_block_reg);
    assign m_tuser  = m_found_reg;

`ifndef ASSERT_OFF
    // an allocation write marks exactly one more block as used
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC_WR) |->
            ($countones(ram_wdata) == $countones(word_reg) + 1))
        else $error("allocation write does not set exactly one bit");

    // a free write never sets a bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FREE_MOD) |-> ((ram_wdata | ram_rdata) == ram_rdata))
        else $error("free write sets a bitmap bit");

    // a new result only comes out of the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result presented outside the output state");

    // a miss always reports block zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result carries a nonzero block");
`endif

endmodule
